// File: hdl/bsc_pkg.sv
// Shared sizes, types and command codes of the Banker's safety check.
`default_nettype none

package bsc_pkg;

  // Problem size.
  localparam int unsigned PROCS     = 8;
  localparam int unsigned RESOURCES = 4;

  // Derived index widths and table depth.
  localparam int unsigned PW    = (PROCS > 1) ? $clog2(PROCS) : 1;
  localparam int unsigned RW    = (RESOURCES > 1) ? $clog2(RESOURCES) : 1;
  localparam int unsigned DEPTH = PROCS * RESOURCES;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW    = $clog2(PROCS + 1);

  // Field and datapath widths.
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned PIDX_W  = 3;
  localparam int unsigned RIDX_W  = 2;
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned WORK_W  = 20;
  localparam int unsigned SEQ_W   = 3;

  // Commands carried in the input tuser.
  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_CELL  = 2'd0,
    CMD_LOAD_AVAIL = 2'd1,
    CMD_CHECK      = 2'd2
  } cmd_e;

  // Verdict codes of a result.
  localparam logic VERDICT_SAFE   = 1'b0;
  localparam logic VERDICT_UNSAFE = 1'b1;

  // Available vector, one count per resource.
  typedef logic [RESOURCES-1:0][CNT_W-1:0] avail_vec_t;

  // One write into the claim and allocation tables.
  typedef struct packed {
    logic              en;
    logic [AW-1:0]     addr;
    logic [CNT_W-1:0]  claim;
    logic [CNT_W-1:0]  alloc;
  } tbl_wr_t;

endpackage

`default_nettype wire

// File: hdl/bsc_tables.sv
// Claim and allocation tables with per-entry valid bits and a registered read port.
`default_nettype none

module bsc_tables (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire bsc_pkg::tbl_wr_t             wr_i,
  input  wire logic [bsc_pkg::AW-1:0]       rd_addr_i,
  output logic      [bsc_pkg::CNT_W-1:0]    rd_claim_o,
  output logic      [bsc_pkg::CNT_W-1:0]    rd_alloc_o
);

  logic [bsc_pkg::CNT_W-1:0] claim_mem [bsc_pkg::DEPTH];
  logic [bsc_pkg::CNT_W-1:0] alloc_mem [bsc_pkg::DEPTH];
  logic [bsc_pkg::DEPTH-1:0] valid_q;
  logic [bsc_pkg::CNT_W-1:0] claim_q;
  logic [bsc_pkg::CNT_W-1:0] alloc_q;
  logic                      rd_valid_q;

  // Memory write and registered read.
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      claim_mem[wr_i.addr] <= wr_i.claim;
      alloc_mem[wr_i.addr] <= wr_i.alloc;
    end
    claim_q <= claim_mem[rd_addr_i];
    alloc_q <= alloc_mem[rd_addr_i];
  end

  // Valid bits make never-written entries read as zero after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        valid_q[wr_i.addr] <= 1'b1;
      end
      rd_valid_q <= valid_q[rd_addr_i];
    end
  end

  assign rd_claim_o = rd_valid_q ? claim_q : '0;
  assign rd_alloc_o = rd_valid_q ? alloc_q : '0;

endmodule

`default_nettype wire

// File: hdl/bsc_alu.sv
// Shared arithmetic unit: need-fits compare and saturating release add.
`default_nettype none

module bsc_alu (
  input  wire logic [bsc_pkg::CNT_W-1:0]  claim_i,
  input  wire logic [bsc_pkg::CNT_W-1:0]  alloc_i,
  input  wire logic [bsc_pkg::WORK_W-1:0] work_i,
  output logic                            fits_o,
  output logic      [bsc_pkg::WORK_W-1:0] sum_o
);

  logic [bsc_pkg::CNT_W-1:0]  need;
  logic [bsc_pkg::WORK_W:0]   sum_wide;

  // Need is clamped at zero when the allocation exceeds the claim.
  always_comb begin
    need   = (claim_i > alloc_i) ? (claim_i - alloc_i) : '0;
    fits_o = (bsc_pkg::WORK_W'(need) <= work_i);
  end

  // Work entries saturate at their full range.
  always_comb begin
    sum_wide = (bsc_pkg::WORK_W + 1)'(work_i) + (bsc_pkg::WORK_W + 1)'(alloc_i);
    sum_o    = sum_wide[bsc_pkg::WORK_W] ? '1 : sum_wide[bsc_pkg::WORK_W-1:0];
  end

endmodule

`default_nettype wire

// File: hdl/bsc_ctrl.sv
// Sequencer that walks processes and resources through the shared unit and emits results.
`default_nettype none

module bsc_ctrl (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire bsc_pkg::avail_vec_t           avail_i,
  output logic      [bsc_pkg::AW-1:0]        rd_addr_o,
  input  wire logic [bsc_pkg::CNT_W-1:0]     rd_claim_i,
  input  wire logic [bsc_pkg::CNT_W-1:0]     rd_alloc_i,
  output logic                               idle_o,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic      [7:0]                    m_axis_tdata,  // [2:0] seq_proc
  output logic      [0:0]                    m_axis_tuser,  // [0] verdict
  output logic                               m_axis_tlast
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIT_RD,
    ST_FIT_CMP,
    ST_REL_RD,
    ST_REL_ADD,
    ST_NEXT,
    ST_EMIT
  } state_e;

  localparam logic [bsc_pkg::PW-1:0] P_LAST = bsc_pkg::PW'(bsc_pkg::PROCS - 1);
  localparam logic [bsc_pkg::RW-1:0] R_LAST = bsc_pkg::RW'(bsc_pkg::RESOURCES - 1);
  localparam logic [bsc_pkg::CW-1:0] C_FULL = bsc_pkg::CW'(bsc_pkg::PROCS);

  state_e                           state_q;
  logic [bsc_pkg::PW-1:0]           p_q;
  logic [bsc_pkg::RW-1:0]           r_q;
  logic [bsc_pkg::CW-1:0]           count_q;
  logic [bsc_pkg::PROCS-1:0]        done_q;
  logic                             found_q;
  logic [bsc_pkg::WORK_W-1:0]       work_q [bsc_pkg::RESOURCES];
  logic [bsc_pkg::PW-1:0]           order_q [bsc_pkg::PROCS];
  logic [bsc_pkg::PW-1:0]           emit_idx_q;
  logic                             valid_q;
  logic                             verdict_q;
  logic                             last_q;
  logic [bsc_pkg::SEQ_W-1:0]        seq_q;
  logic                             fits;
  logic [bsc_pkg::WORK_W-1:0]       sum;
  logic                             rel_done;

  // Table address of the current process and resource.
  assign rd_addr_o = bsc_pkg::AW'(p_q) * bsc_pkg::AW'(bsc_pkg::RESOURCES)
                   + bsc_pkg::AW'(r_q);

  bsc_alu u_alu (
    .claim_i (rd_claim_i),
    .alloc_i (rd_alloc_i),
    .work_i  (work_q[r_q]),
    .fits_o  (fits),
    .sum_o   (sum)
  );

  assign rel_done = (state_q == ST_REL_ADD) && (r_q == R_LAST);

  // Safe sequence buffer, written when a process finishes.
  always_ff @(posedge clk_i) begin
    if (rel_done) begin
      order_q[count_q[bsc_pkg::PW-1:0]] <= p_q;
    end
  end

  // Sequencer state and registered result word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      p_q        <= '0;
      r_q        <= '0;
      count_q    <= '0;
      done_q     <= '0;
      found_q    <= 1'b0;
      emit_idx_q <= '0;
      valid_q    <= 1'b0;
      verdict_q  <= bsc_pkg::VERDICT_SAFE;
      last_q     <= 1'b0;
      seq_q      <= '0;
      for (int i = 0; i < bsc_pkg::RESOURCES; i++) begin
        work_q[i] <= '0;
      end
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            for (int i = 0; i < bsc_pkg::RESOURCES; i++) begin
              work_q[i] <= bsc_pkg::WORK_W'(avail_i[i]);
            end
            done_q  <= '0;
            count_q <= '0;
            found_q <= 1'b0;
            p_q     <= '0;
            r_q     <= '0;
            state_q <= ST_FIT_RD;
          end
        end
        ST_FIT_RD: begin
          state_q <= done_q[p_q] ? ST_NEXT : ST_FIT_CMP;
        end
        ST_FIT_CMP: begin
          if (!fits) begin
            r_q     <= '0;
            state_q <= ST_NEXT;
          end else if (r_q == R_LAST) begin
            r_q     <= '0;
            state_q <= ST_REL_RD;
          end else begin
            r_q     <= r_q + 1'b1;
            state_q <= ST_FIT_RD;
          end
        end
        ST_REL_RD: begin
          state_q <= ST_REL_ADD;
        end
        ST_REL_ADD: begin
          work_q[r_q] <= sum;
          if (r_q == R_LAST) begin
            done_q[p_q] <= 1'b1;
            count_q     <= count_q + 1'b1;
            found_q     <= 1'b1;
            r_q         <= '0;
            state_q     <= ST_NEXT;
          end else begin
            r_q     <= r_q + 1'b1;
            state_q <= ST_REL_RD;
          end
        end
        ST_NEXT: begin
          if (p_q != P_LAST) begin
            p_q     <= p_q + 1'b1;
            state_q <= ST_FIT_RD;
          end else if (count_q == C_FULL) begin
            // Every process finished: stream the safe sequence.
            emit_idx_q <= '0;
            valid_q    <= 1'b1;
            verdict_q  <= bsc_pkg::VERDICT_SAFE;
            seq_q      <= bsc_pkg::SEQ_W'(order_q[0]);
            last_q     <= (P_LAST == '0);
            state_q    <= ST_EMIT;
          end else if (found_q) begin
            p_q     <= '0;
            found_q <= 1'b0;
            state_q <= ST_FIT_RD;
          end else begin
            // A pass finished nothing: one unsafe word.
            valid_q   <= 1'b1;
            verdict_q <= bsc_pkg::VERDICT_UNSAFE;
            seq_q     <= '0;
            last_q    <= 1'b1;
            state_q   <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (m_axis_tready) begin
            if (last_q) begin
              valid_q <= 1'b0;
              last_q  <= 1'b0;
              state_q <= ST_IDLE;
            end else begin
              emit_idx_q <= emit_idx_q + 1'b1;
              seq_q      <= bsc_pkg::SEQ_W'(order_q[emit_idx_q + 1'b1]);
              last_q     <= ((emit_idx_q + 1'b1) == P_LAST);
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign idle_o        = (state_q == ST_IDLE);
  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = 8'(seq_q);
  assign m_axis_tuser  = verdict_q;
  assign m_axis_tlast  = last_q;

  // A result word is shown only while results are being streamed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (state_q == ST_EMIT))
    else $error("result word outside emit state");

  // The finish count tracks the finished-process flags.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(done_q) == int'(count_q))
    else $error("finish count disagrees with done flags");

  // A check starts only from idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> (state_q == ST_IDLE))
    else $error("check started while busy");

  // An unsafe verdict is a single final word with process zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser[0] == bsc_pkg::VERDICT_UNSAFE))
      |-> (m_axis_tlast && (m_axis_tdata == '0)))
    else $error("malformed unsafe word");

  // A finished process is never released again in the same check.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_REL_RD) |-> !done_q[p_q])
    else $error("finished process released twice");

endmodule

`default_nettype wire

// File: hdl/bankers_safety_check_top.sv
// Top level of the Banker's algorithm safety check: load decode, available vector, sequencer.
//
//   Channel   Direction  Word contents (low bit first)
//   s_axis    in         tuser: cmd; tdata: proc_index, res_index, max_claim,
//                        allocated, avail_value
//   m_axis    out        tuser: verdict; tdata: seq_proc; tlast: last
//
// Load words are taken while idle and s_axis_tready stays high between them.
// A check holds s_axis_tready low until its last result word has left. On
// each pass an unfinished process has its resources read and compared one at
// a time before the sweep advances, a finished one is read and skipped, and
// each process releases once with a read and an add per resource, all through
// the single table read port and the shared arithmetic unit.
// Results leave one per m_axis handshake; a stalled output just holds.
// Reset clears the table valid bits, available counts and the sequencer.
`default_nettype none

module bankers_safety_check_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [2:0] proc_index, [4:3] res_index, [20:5] max_claim, [36:21] allocated,
  // [52:37] avail_value
  input  wire logic [55:0] s_axis_tdata,
  input  wire logic [1:0]  s_axis_tuser,  // [1:0] cmd
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [7:0]  m_axis_tdata,  // [2:0] seq_proc
  output logic      [0:0]  m_axis_tuser,  // [0] verdict
  output logic             m_axis_tlast
);

  logic                             accept;
  logic                             idle;
  logic [bsc_pkg::PIDX_W-1:0]       proc_idx;
  logic [bsc_pkg::RIDX_W-1:0]       res_idx;
  logic [bsc_pkg::CNT_W-1:0]        max_claim;
  logic [bsc_pkg::CNT_W-1:0]        allocated;
  logic [bsc_pkg::CNT_W-1:0]        avail_value;
  logic                             proc_ok;
  logic                             res_ok;
  logic                             start;
  logic                             avail_we;
  bsc_pkg::tbl_wr_t                 tbl_wr;
  bsc_pkg::avail_vec_t              avail_q;
  logic [bsc_pkg::AW-1:0]           rd_addr;
  logic [bsc_pkg::CNT_W-1:0]        rd_claim;
  logic [bsc_pkg::CNT_W-1:0]        rd_alloc;

  // Unpack the input word.
  assign proc_idx    = s_axis_tdata[2:0];
  assign res_idx     = s_axis_tdata[4:3];
  assign max_claim   = s_axis_tdata[20:5];
  assign allocated   = s_axis_tdata[36:21];
  assign avail_value = s_axis_tdata[52:37];

  assign s_axis_tready = idle;
  assign accept        = s_axis_tvalid && idle;

  // Out-of-range addresses are dropped.
  assign proc_ok = (5'(proc_idx) < 5'(bsc_pkg::PROCS));
  assign res_ok  = (4'(res_idx) < 4'(bsc_pkg::RESOURCES));

  // Command decode.
  always_comb begin
    tbl_wr.en    = 1'b0;
    tbl_wr.addr  = bsc_pkg::AW'(bsc_pkg::PW'(proc_idx)) * bsc_pkg::AW'(bsc_pkg::RESOURCES)
                 + bsc_pkg::AW'(bsc_pkg::RW'(res_idx));
    tbl_wr.claim = max_claim;
    tbl_wr.alloc = allocated;
    avail_we     = 1'b0;
    start        = 1'b0;
    if (accept) begin
      case (bsc_pkg::cmd_e'(s_axis_tuser))
        bsc_pkg::CMD_LOAD_CELL:  tbl_wr.en = proc_ok && res_ok;
        bsc_pkg::CMD_LOAD_AVAIL: avail_we  = res_ok;
        bsc_pkg::CMD_CHECK:      start     = 1'b1;
        default: ;
      endcase
    end
  end

  // Available counts.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avail_q <= '0;
    end else if (avail_we) begin
      avail_q[bsc_pkg::RW'(res_idx)] <= avail_value;
    end
  end

  bsc_tables u_tables (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (tbl_wr),
    .rd_addr_i  (rd_addr),
    .rd_claim_o (rd_claim),
    .rd_alloc_o (rd_alloc)
  );

  bsc_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .avail_i       (avail_q),
    .rd_addr_o     (rd_addr),
    .rd_claim_i    (rd_claim),
    .rd_alloc_i    (rd_alloc),
    .idle_o        (idle),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire
